// File: rtl/tml_pkg.sv
// Shared definitions for the texture memory loader.
// Item kind codes, status codes, store geometry and the placement structs.
// No dependencies.
package tml_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int TILE_COUNT  = 8;
  localparam int BLOCK_LIMIT = 2048;
  localparam int WORD_BYTES  = 8;
  localparam int STORE_WORDS = STORE_BYTES / WORD_BYTES;
  localparam int WIDX_W      = $clog2(STORE_WORDS);
  localparam int TIDX_W      = $clog2(TILE_COUNT);

  // input item kinds
  localparam logic [2:0] K_SET_TILE     = 3'd0;
  localparam logic [2:0] K_SET_SIZE     = 3'd1;
  localparam logic [2:0] K_LOAD_TILE    = 3'd2;
  localparam logic [2:0] K_LOAD_BLOCK   = 3'd3;
  localparam logic [2:0] K_LOAD_PALETTE = 3'd4;
  localparam logic [2:0] K_SRC_DATA     = 3'd5;
  localparam logic [2:0] K_STORE_READ   = 3'd6;

  // result kinds
  localparam logic [1:0] R_READ_REQ = 2'd0;
  localparam logic [1:0] R_STORE    = 2'd1;
  localparam logic [1:0] R_FINISHED = 2'd2;

  // finish status
  localparam logic [1:0] S_LOADED  = 2'd0;
  localparam logic [1:0] S_INVALID = 2'd1;
  localparam logic [1:0] S_HALTED  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_IMAGE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [1:0] REG_IMAGE_SIZE    = 2'd2;

  typedef struct packed {
    logic       palette;
    logic       wide;     // 32-bit or YUV: split banks
    logic       yuv;
    logic [1:0] tsize;
    logic [1:0] isize;
  } place_cfg_t;

  typedef struct packed {
    logic [WIDX_W-1:0]     idx;
    logic [WORD_BYTES-1:0] be;
    logic [63:0]           data;
  } ram_wr_t;

endpackage

// File: rtl/tml_ram.sv
// Generic simple dual-port RAM: one byte-enabled write port, one registered read port.
// No dependencies.
module tml_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH/8-1:0]       be_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < WIDTH / 8; b++) begin
        if (be_i[b]) begin
          mem_q[waddr_i][8*b +: 8] <= wdata_i[8*b +: 8];
        end
      end
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/tml_place.sv
// Lane placement of one fetched source word into the texture store.
// Row XOR swizzle, split banks for 32-bit/YUV, palette lane copy. Uses tml_pkg.
module tml_place (
  input  tml_pkg::place_cfg_t cfg_i,
  input  logic [11:0]         x_i,
  input  logic [11:0]         base_i,
  input  logic                flip_i,
  input  logic                src_odd_i,
  input  logic                high_i,
  input  logic [63:0]         word_i,
  output tml_pkg::ram_wr_t    wr_o
);
  import tml_pkg::*;

  logic [19:0] xs;
  logic [11:0] pal_off;
  logic [11:0] pal_dst;
  logic [11:0] nar_dst;
  logic [10:0] wd;
  logic [10:0] aw;
  logic [31:0] h32;
  logic [7:0]  b [8];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      b[k] = word_i[8*k +: 8];
    end
  end

  assign xs = 20'(x_i) << cfg_i.tsize;

  always_comb begin
    case (cfg_i.isize)
      2'd1:    pal_off = {xs[10:0], 1'b0};
      2'd2:    pal_off = {xs[8:0], 3'b000};
      default: pal_off = {xs[10:2], 3'b000};
    endcase
  end

  assign pal_dst = base_i + pal_off;
  assign nar_dst = base_i + {xs[12:4], 3'b000};
  assign wd      = base_i[10:0] + (cfg_i.yuv ? x_i[10:0] : {x_i[9:0], 1'b0});
  assign aw      = wd ^ {8'b0, flip_i, 2'b00};

  always_comb begin
    if (high_i) begin
      h32 = cfg_i.yuv ? {b[7], b[5], b[3], b[1]} : {b[7], b[6], b[3], b[2]};
    end else begin
      h32 = cfg_i.yuv ? {b[6], b[4], b[2], b[0]} : {b[5], b[4], b[1], b[0]};
    end
  end

  always_comb begin
    if (cfg_i.palette) begin
      wr_o.idx  = pal_dst[11:3];
      wr_o.be   = '1;
      wr_o.data = src_odd_i ? word_i : {4{word_i[15:0]}};
    end else if (cfg_i.wide) begin
      wr_o.idx  = {high_i, aw[10:3]};
      wr_o.be   = aw[2] ? 8'hf0 : 8'h0f;
      wr_o.data = {h32, h32};
    end else begin
      wr_o.idx  = nar_dst[11:3];
      wr_o.be   = '1;
      wr_o.data = flip_i ? {word_i[31:0], word_i[63:32]} : word_i;
    end
  end

endmodule

// File: rtl/texture_memory_loader.sv
// Texture memory loader top level: APB registers, tile table, sequencer, shared multiplier.
// Depends on tml_pkg, tml_ram and tml_place.
// States per item: table write IDLE only; store read RD, EMIT; load command CHK, MUL2,
// ADDR, EMIT (CHK, EMIT if CHK rejects it); source word D1, D2 (not palette), WR1, WR2
// (32-bit/YUV only), UPD, EMIT. The 12x12 multiplier is shared by all address steps; the
// single store write port takes one bank per state. Not ready while an item is in work.
// After reset a pass clears all 512 store words; registers are taken meanwhile.
module texture_memory_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] command_i,
  input  logic [63:0] source_word_i,
  input  logic [8:0]  store_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [23:0] fetch_address_o,
  output logic [63:0] store_word_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import tml_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHK, ST_MUL2, ST_ADDR, ST_D1, ST_D2,
    ST_WR1, ST_WR2, ST_UPD, ST_RD, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {MODE_IDLE, MODE_TILE, MODE_BLOCK, MODE_PALETTE} mode_e;

  // registers
  logic [23:0] image_address_q;
  logic [10:0] image_width_q;
  logic [1:0]  image_size_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_address_q <= '0;
      image_width_q   <= 11'd1;
      image_size_q    <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_IMAGE_ADDRESS: image_address_q <= pwdata[23:0];
        REG_IMAGE_WIDTH:   image_width_q   <= pwdata[10:0];
        REG_IMAGE_SIZE:    image_size_q    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMAGE_ADDRESS: prdata = {8'b0, image_address_q};
      REG_IMAGE_WIDTH:   prdata = {21'b0, image_width_q};
      REG_IMAGE_SIZE:    prdata = {30'b0, image_size_q};
      default:           prdata = '0;
    endcase
  end

  state_e      state_q;
  mode_e       mode_q;
  logic [8:0]  tmem_q   [TILE_COUNT];
  logic [8:0]  stride_q [TILE_COUNT];
  logic [1:0]  tsize_q  [TILE_COUNT];
  logic [2:0]  fmt_q    [TILE_COUNT];
  logic [63:0] cmd_q;
  logic [2:0]  kind_q;
  logic [63:0] src_q;
  logic [23:0] prod_q;
  logic [WIDX_W-1:0] clr_q;

  // latched at load start
  logic [11:0] lat_tmem_q;
  logic [8:0]  lat_stride_q;
  logic [1:0]  lat_tsize_q;
  logic        lat_yuv_q;
  logic [1:0]  lat_isize_q;
  logic [12:0] lat_pitch_q;
  logic [3:0]  lat_step_q;
  logic [11:0] slope_q;
  logic [11:0] col_total_q;
  logic [11:0] col_q;
  logic [10:0] row_total_q;
  logic [10:0] row_q;
  logic [23:0] sra_q;
  logic        flip_q;

  logic [1:0]  pend_kind_q;
  logic [23:0] pend_addr_q;
  logic [63:0] pend_word_q;
  logic [1:0]  pend_status_q;
  logic        pend_last_q;

  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [23:0] out_addr_q;
  logic [63:0] out_word_q;
  logic [1:0]  out_status_q;
  logic        out_last_q;

  // command decode
  logic [11:0] sl, tl, sh, th, width_c, y0, x0, wm1;
  logic [2:0]  tidx;
  logic        is_block, is_pal, yuv_c, chk_fail;
  logic [1:0]  d_size, chk_stat, bps, lat_bps;
  logic [2:0]  d_fmt, shamt, lat_shamt;
  logic [10:0] row_total_c;
  logic [3:0]  ppw;

  assign sl       = cmd_q[55:44];
  assign tl       = cmd_q[43:32];
  assign sh       = cmd_q[23:12];
  assign th       = cmd_q[11:0];
  assign tidx     = cmd_q[26:24];
  assign is_block = (kind_q == K_LOAD_BLOCK);
  assign is_pal   = (kind_q == K_LOAD_PALETTE);
  assign d_size   = tsize_q[tidx];
  assign d_fmt    = fmt_q[tidx];
  assign yuv_c    = (d_fmt == 3'd1);
  assign width_c  = is_block ? (sh - sl + 12'd1)
                             : ({2'b0, sh[11:2]} - {2'b0, sl[11:2]} + 12'd1);
  assign wm1      = width_c - 12'd1;
  assign y0       = is_block ? tl : {2'b0, tl[11:2]};
  assign x0       = is_block ? sl : {2'b0, sl[11:2]};
  assign shamt    = 3'd4 - {1'b0, image_size_q};
  assign bps      = image_size_q - 2'd1;
  assign ppw      = 4'd8 >> bps;
  assign row_total_c = (is_block || is_pal) ? 11'd1
                     : ({1'b0, th[11:2]} - {1'b0, tl[11:2]} + 11'd1);
  assign lat_shamt = 3'd4 - {1'b0, lat_isize_q};
  assign lat_bps   = lat_isize_q - 2'd1;

  always_comb begin
    chk_fail = 1'b1;
    chk_stat = S_INVALID;
    if (is_pal && (th[11:2] > tl[11:2])) begin
      chk_stat = S_HALTED;
    end else if (!is_block && (th[11:2] < tl[11:2])) begin
      chk_stat = S_INVALID;
    end else if (width_c == 12'd0 || (is_block && width_c > 12'(BLOCK_LIMIT))) begin
      chk_stat = S_INVALID;
    end else if (yuv_c && (d_size != 2'd2 || image_size_q != 2'd2)) begin
      chk_stat = S_INVALID;
    end else if (image_size_q == 2'd0) begin
      chk_stat = S_HALTED;
    end else if (d_size == 2'd3 && (d_fmt != 3'd0 || is_pal)) begin
      chk_stat = S_INVALID;
    end else if (!is_pal && ((image_size_q == 2'd3 && d_size < 2'd2) ||
                             (image_size_q == 2'd2 && d_size == 2'd0))) begin
      chk_stat = S_INVALID;
    end else begin
      chk_fail = 1'b0;
    end
  end

  // shared multiplier operands
  logic [11:0] mul_a, mul_b, t_c;

  assign t_c = (mode_q == MODE_BLOCK) ? prod_q[22:11] : {1'b0, row_q};

  always_comb begin
    unique case (state_q)
      ST_CHK:  begin mul_a = wm1 >> shamt;   mul_b = th; end
      ST_MUL2: begin mul_a = y0;             mul_b = {1'b0, image_width_q}; end
      ST_D1:   begin mul_a = col_q >> lat_shamt; mul_b = slope_q; end
      ST_D2:   begin mul_a = t_c;            mul_b = {lat_stride_q, 3'b000}; end
      default: begin mul_a = '0;             mul_b = '0; end
    endcase
  end

  // counter update and fetch address
  logic [12:0] col_sum;
  logic        col_wrap;
  logic [11:0] col_next;
  logic [10:0] row_next;
  logic [23:0] sra_next, fetch_next, fetch_cur, sra_start;

  assign col_sum    = {1'b0, col_q} + 13'(lat_step_q);
  assign col_wrap   = (col_sum >= {1'b0, col_total_q});
  assign col_next   = col_wrap ? 12'd0 : col_sum[11:0];
  assign row_next   = row_q + 11'd1;
  assign sra_next   = col_wrap ? (sra_q + 24'(lat_pitch_q)) : sra_q;
  assign fetch_next = sra_next + (24'(col_next) << lat_bps);
  assign fetch_cur  = sra_q + (24'(col_q) << lat_bps);
  assign sra_start  = image_address_q + ((prod_q + 24'(x0)) << lat_bps);

  // placement and store
  place_cfg_t pcfg;
  ram_wr_t    pwr;
  logic [11:0] base_c;
  logic        ram_we, ram_re;
  logic [WIDX_W-1:0] ram_waddr;
  logic [7:0]  ram_be;
  logic [63:0] ram_wdata, ram_rdata;

  assign pcfg.palette = (mode_q == MODE_PALETTE);
  assign pcfg.wide    = (lat_tsize_q == 2'd3) || lat_yuv_q;
  assign pcfg.yuv     = lat_yuv_q;
  assign pcfg.tsize   = lat_tsize_q;
  assign pcfg.isize   = lat_isize_q;
  assign base_c = lat_tmem_q + ((mode_q == MODE_PALETTE) ? 12'd0 : prod_q[11:0]);

  tml_place u_place (
    .cfg_i    (pcfg),
    .x_i      (col_q),
    .base_i   (base_c),
    .flip_i   (flip_q),
    .src_odd_i(fetch_cur[0]),
    .high_i   (state_q == ST_WR2),
    .word_i   (src_q),
    .wr_o     (pwr)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pwr.idx;
    ram_be    = pwr.be;
    ram_wdata = pwr.data;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_be    = '1;
      ram_wdata = '0;
    end else if (state_q == ST_WR1 || state_q == ST_WR2) begin
      ram_we = 1'b1;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign ram_re = in_ready_o && in_valid_i && (kind_i == K_STORE_READ);

  tml_ram #(
    .WIDTH(64),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .be_i   (ram_be),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(store_index_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mode_q      <= MODE_IDLE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TILE_COUNT; i++) begin
        tmem_q[i]   <= '0;
        stride_q[i] <= '0;
        tsize_q[i]  <= '0;
        fmt_q[i]    <= '0;
      end
    end else begin
      // row offset product stays put across both bank writes
      if (state_q != ST_WR1) begin
        prod_q <= 24'(mul_a) * 24'(mul_b);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == WIDX_W'(STORE_WORDS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            case (kind_i) inside
              K_SET_TILE: begin
                tmem_q[command_i[26:24]]   <= command_i[40:32];
                stride_q[command_i[26:24]] <= command_i[49:41];
                tsize_q[command_i[26:24]]  <= command_i[52:51];
                fmt_q[command_i[26:24]]    <= command_i[55:53];
              end
              K_LOAD_TILE, K_LOAD_BLOCK, K_LOAD_PALETTE: begin
                cmd_q   <= command_i;
                kind_q  <= kind_i;
                mode_q  <= MODE_IDLE;
                state_q <= ST_CHK;
              end
              K_SRC_DATA: begin
                if (mode_q != MODE_IDLE) begin
                  src_q   <= source_word_i;
                  state_q <= (mode_q == MODE_PALETTE) ? ST_WR1 : ST_D1;
                end
              end
              K_STORE_READ: state_q <= ST_RD;
              default: ;  // tile size writes and unused kinds leave no trace
            endcase
          end
        end
        ST_CHK: begin
          if (chk_fail) begin
            pend_kind_q   <= R_FINISHED;
            pend_addr_q   <= '0;
            pend_word_q   <= '0;
            pend_status_q <= chk_stat;
            pend_last_q   <= 1'b1;
            state_q       <= ST_EMIT;
          end else begin
            state_q <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (is_block && (prod_q[23:11] != 13'd0) && (image_size_q > d_size)) begin
            pend_kind_q   <= R_FINISHED;
            pend_addr_q   <= '0;
            pend_word_q   <= '0;
            pend_status_q <= S_INVALID;
            pend_last_q   <= 1'b1;
            state_q       <= ST_EMIT;
          end else begin
            lat_tmem_q   <= {tmem_q[tidx], 3'b000};
            lat_stride_q <= stride_q[tidx];
            lat_tsize_q  <= d_size;
            lat_yuv_q    <= yuv_c;
            lat_isize_q  <= image_size_q;
            lat_pitch_q  <= {2'b00, image_width_q} << bps;
            lat_step_q   <= (is_pal && image_size_q == 2'd2) ? 4'd1 : ppw;
            slope_q      <= th;
            col_total_q  <= width_c;
            col_q        <= '0;
            row_q        <= '0;
            row_total_q  <= row_total_c;
            state_q      <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          sra_q         <= sra_start;
          mode_q        <= is_block ? MODE_BLOCK : (is_pal ? MODE_PALETTE : MODE_TILE);
          pend_kind_q   <= R_READ_REQ;
          pend_addr_q   <= sra_start;
          pend_word_q   <= '0;
          pend_status_q <= S_LOADED;
          pend_last_q   <= 1'b0;
          state_q       <= ST_EMIT;
        end
        ST_D1: state_q <= ST_D2;
        ST_D2: begin
          flip_q  <= t_c[0];
          state_q <= ST_WR1;
        end
        ST_WR1: begin
          state_q <= (pcfg.wide && !pcfg.palette) ? ST_WR2 : ST_UPD;
        end
        ST_WR2: state_q <= ST_UPD;
        ST_UPD: begin
          col_q   <= col_next;
          sra_q   <= sra_next;
          state_q <= ST_EMIT;
          pend_word_q   <= '0;
          pend_status_q <= S_LOADED;
          if (col_wrap) begin
            row_q <= row_next;
          end
          if (col_wrap && (row_next >= row_total_q)) begin
            mode_q      <= MODE_IDLE;
            pend_kind_q <= R_FINISHED;
            pend_addr_q <= '0;
            pend_last_q <= 1'b1;
          end else begin
            pend_kind_q <= R_READ_REQ;
            pend_addr_q <= fetch_next;
            pend_last_q <= 1'b0;
          end
        end
        ST_RD: begin
          pend_kind_q   <= R_STORE;
          pend_addr_q   <= '0;
          pend_word_q   <= ram_rdata;
          pend_status_q <= S_LOADED;
          pend_last_q   <= 1'b1;
          state_q       <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= pend_kind_q;
            out_addr_q   <= pend_addr_q;
            out_word_q   <= pend_word_q;
            out_status_q <= pend_status_q;
            out_last_q   <= pend_last_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign fetch_address_o = out_addr_q;
  assign store_word_o    = out_word_q;
  assign status_o        = out_status_q;
  assign last_o          = out_last_q;

endmodule
